[hw/rtl/id_allocator_with_payload_core_assert.svh]
// Assertion macros for the id allocator core
`ifndef ID_ALLOCATOR_WITH_PAYLOAD_CORE_ASSERT_SVH
`define ID_ALLOCATOR_WITH_PAYLOAD_CORE_ASSERT_SVH

// Invariant checked at every clock edge out of reset
`define IDAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies consequence in the next
`define IDAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/idap_pkg.sv]
// Shared types and constants for the id allocator core
package idap_pkg;

  // Used map is kept as rows of this many bits
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NOT_USED = 2'd2
  } status_e;

  // Outcome of a first-free search over one row
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } scan_res_t;

endpackage

[hw/rtl/id_allocator_with_payload_core.sv]
// Id allocator core: bitmap pool of ids with a payload word per id
//
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   target_id[7:0], payload_in[39:8]            kind[1:0]
//  m_axis   out  result_id[7:0], payload_out[39:8],          status[1:0]
//                used_count[48:40], free_count[57:49], 0 pad
//
// Steps: remove, find and unknown kinds are accepted with a read of the
//   used-map row and payload RAM, then modified and written back. Insert
//   reads one row of 32 ids per step from the hint row on, until a free id
//   or the last row is found; the used-map RAM read port sets this.
// Reset: control, counts and per-row valid flops clear at once; a row that
//   is not valid reads as all free, so no clearing pass is run.
// Stalls: one output register; a new beat is taken while a result waits,
//   and the block holds in its lookup state until that register is free.
`include "id_allocator_with_payload_core_assert.svh"

module id_allocator_with_payload_core #(
  parameter int NUM_IDS       = 256,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // target_id[7:0], payload_in[39:8]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_id[7:0], payload_out[39:8],
                                      // used_count[48:40], free_count[57:49]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int WORD_W    = idap_pkg::WORD_W;
  localparam int BIT_W     = idap_pkg::BIT_W;
  localparam int ROWS      = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ID_W      = ROW_W + BIT_W;
  localparam int HINT_W    = ID_W + 1;
  localparam int CNT_W     = $clog2(NUM_IDS + 1);
  localparam int FULL_ROWS = NUM_IDS / WORD_W;
  localparam int TAIL      = NUM_IDS % WORD_W;
  // ids within the pool in the last, partial row
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << TAIL) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  state_e                    state_q, state_d;
  idap_pkg::kind_e           kind_q;
  logic [7:0]                tid_q;
  logic [PAYLOAD_WIDTH-1:0]  pin_q;
  logic                      in_range_q;
  logic                      hint_full_q;
  logic                      first_q;
  logic [ROW_W-1:0]          scan_row_q;
  logic [HINT_W-1:0]         hint_q, hint_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [ROWS-1:0]           row_vld_q;

  // used map RAM (one row of ids a word) and payload RAM
  logic [WORD_W-1:0]         map_mem [ROWS];
  logic [WORD_W-1:0]         map_rd_q;
  logic                      map_rv_q;
  logic [PAYLOAD_WIDTH-1:0]  pay_mem [NUM_IDS];
  logic [PAYLOAD_WIDTH-1:0]  pay_rd_q;

  logic                      out_valid_q;
  idap_pkg::status_e         out_status_q;
  logic [7:0]                out_id_q;
  logic [31:0]               out_pay_q;
  logic [8:0]                out_used_q;
  logic [8:0]                out_free_q;

  logic                      s_accept;
  logic                      out_free;
  logic                      rd_en;
  logic [ROW_W-1:0]          rd_row;
  logic                      advance;
  logic                      commit;
  logic                      map_we;
  logic [WORD_W-1:0]         map_wdata;
  logic                      pay_we;
  logic [ID_W-1:0]           pay_waddr;
  logic [ID_W-1:0]           in_tid;
  logic [ID_W-1:0]           tid_full;
  logic [WORD_W-1:0]         row_eff;
  logic [WORD_W-1:0]         row_mask;
  logic                      last_row;
  idap_pkg::scan_res_t       scan;
  logic [ID_W-1:0]           new_id;
  idap_pkg::status_e         res_status;
  logic [7:0]                res_id;
  logic [31:0]               res_pay;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_tid   = ID_W'(s_axis_tdata[7:0]);
  assign tid_full = ID_W'(tid_q);

  // a row never written since reset reads as all free
  assign row_eff  = map_rv_q ? map_rd_q : '0;
  assign row_mask = (32'(scan_row_q) < FULL_ROWS) ? '1 : LAST_MASK;
  assign last_row = (32'(scan_row_q) == ROWS - 1);
  assign new_id   = {scan_row_q, scan.pos};

  idap_row_scan u_scan (
    .avail_i (~row_eff & row_mask),
    .lo_i    (hint_q[BIT_W-1:0]),
    .lo_en_i (first_q),
    .res_o   (scan)
  );

  // sequencing: accept, then look up / scan rows until the result is known
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_row  = scan_row_q;
    advance = 1'b0;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          rd_en   = 1'b1;
          rd_row  = (s_axis_tuser == idap_pkg::KIND_INSERT) ? hint_q[ID_W-1:BIT_W]
                                                            : in_tid[ID_W-1:BIT_W];
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (kind_q == idap_pkg::KIND_INSERT && !hint_full_q && !scan.found
            && !last_row) begin
          advance = 1'b1;
          rd_en   = 1'b1;
          rd_row  = scan_row_q + ROW_W'(1);
        end else if (out_free) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result and read-modify-write of the row, only applied on commit
  always_comb begin
    res_status = idap_pkg::STATUS_OK;
    res_id     = tid_q;
    res_pay    = '0;
    cnt_d      = cnt_q;
    hint_d     = hint_q;
    map_we     = 1'b0;
    map_wdata  = row_eff;
    pay_we     = 1'b0;
    pay_waddr  = new_id;
    case (kind_q) inside
      idap_pkg::KIND_INSERT: begin
        if (!hint_full_q && scan.found) begin
          res_id    = 8'(new_id);
          map_wdata = row_eff | (WORD_W'(1) << scan.pos);
          map_we    = commit;
          pay_we    = commit;
          if (commit) begin
            cnt_d  = cnt_q + CNT_W'(1);
            hint_d = HINT_W'(new_id) + HINT_W'(1);
          end
        end else begin
          res_status = idap_pkg::STATUS_FULL;
          res_id     = '0;
        end
      end
      idap_pkg::KIND_REMOVE, idap_pkg::KIND_FIND: begin
        if (in_range_q && row_eff[tid_full[BIT_W-1:0]]) begin
          res_pay = 32'(pay_rd_q);
          if (kind_q == idap_pkg::KIND_REMOVE) begin
            map_wdata = row_eff & ~(WORD_W'(1) << tid_full[BIT_W-1:0]);
            map_we    = commit;
            if (commit) begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CNT_W'(1);
              end
              if ({1'b0, tid_full} < hint_q) begin
                hint_d = HINT_W'(tid_full);
              end
            end
          end
        end else begin
          res_status = idap_pkg::STATUS_NOT_USED;
        end
      end
      default: ;
    endcase
  end

  // RAMs: one read and one write a cycle; the sequencer never reads and
  // writes in the same cycle, so no forwarding path is needed
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      map_rd_q <= map_mem[rd_row];
    end
    if (map_we) begin
      map_mem[scan_row_q] <= map_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      pay_rd_q <= pay_mem[in_tid];
    end
    if (pay_we) begin
      pay_mem[pay_waddr] <= pin_q;
    end
  end

  // beat capture, payload regs need no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      kind_q <= idap_pkg::kind_e'(s_axis_tuser);
      tid_q  <= s_axis_tdata[7:0];
      pin_q  <= PAYLOAD_WIDTH'(s_axis_tdata[39:8]);
    end
    if (commit) begin
      out_status_q <= res_status;
      out_id_q     <= res_id;
      out_pay_q    <= res_pay;
      out_used_q   <= 9'(cnt_d);
      out_free_q   <= 9'(32'(NUM_IDS) - 32'(cnt_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_range_q  <= 1'b0;
      hint_full_q <= 1'b0;
      first_q     <= 1'b0;
      scan_row_q  <= '0;
      hint_q      <= '0;
      cnt_q       <= '0;
      row_vld_q   <= '0;
      map_rv_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      cnt_q   <= cnt_d;
      if (s_accept) begin
        in_range_q  <= ({24'd0, s_axis_tdata[7:0]} < 32'(NUM_IDS));
        hint_full_q <= (32'(hint_q) >= NUM_IDS);
        first_q     <= 1'b1;
      end else if (advance) begin
        first_q     <= 1'b0;
      end
      if (rd_en) begin
        scan_row_q <= rd_row;
        map_rv_q   <= row_vld_q[rd_row];
      end
      if (map_we) begin
        row_vld_q[scan_row_q] <= 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, out_free_q, out_used_q, out_pay_q, out_id_q};

  // count moves by at most one: difference + 1 stays within 0..2 modulo width
  `IDAP_ASSERT(a_cnt_range, 32'(cnt_q) <= NUM_IDS, "used count exceeds pool")
  `IDAP_ASSERT(a_hint_range, 32'(hint_q) <= NUM_IDS, "search hint past pool end")
  `IDAP_ASSERT(a_cnt_step, cnt_q - $past(cnt_q) + CNT_W'(1) <= CNT_W'(2), "used count jumped")
  `IDAP_ASSERT_NEXT(a_accept_look, s_accept, state_q == ST_LOOK && first_q, "lookup not started")
  `IDAP_ASSERT_NEXT(a_commit_valid, commit, m_axis_tvalid, "committed result not presented")

endmodule

[hw/rtl/idap_row_scan.sv]
// Lowest free bit search over one row of the used map
module idap_row_scan (
  input  logic [idap_pkg::WORD_W-1:0] avail_i,  // 1 = free and in range
  input  logic [idap_pkg::BIT_W-1:0]  lo_i,     // lowest bit allowed
  input  logic                        lo_en_i,  // apply lo_i (first row only)
  output idap_pkg::scan_res_t         res_o
);

  logic [idap_pkg::WORD_W-1:0] lo_mask;
  logic [idap_pkg::WORD_W-1:0] masked;
  logic [idap_pkg::WORD_W-1:0] lowest;
  logic [idap_pkg::BIT_W-1:0]  pos;

  always_comb begin
    lo_mask = lo_en_i ? ~((idap_pkg::WORD_W'(1) << lo_i) - idap_pkg::WORD_W'(1))
                      : '1;
    masked  = avail_i & lo_mask;
    // isolate lowest set bit, then encode with an OR over the bits
    lowest  = masked & (~masked + idap_pkg::WORD_W'(1));
    pos     = '0;
    for (int i = 0; i < idap_pkg::WORD_W; i++) begin
      pos = pos | (lowest[i] ? idap_pkg::BIT_W'(i) : '0);
    end
    res_o.found = |masked;
    res_o.pos   = pos;
  end

endmodule

[verif/id_pool_checker.sv]
// Scoreboard for the id allocator: mirrors the pool and checks every result beat
`timescale 1ns / 1ps

module id_pool_checker #(
  parameter int NUM_IDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // target_id[7:0], payload_in[39:8]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // result_id[7:0], payload_out[39:8],
                                      // used_count[48:40], free_count[57:49]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  output int          fail_count_o,
  output int          outstanding_o
);

  typedef struct packed {
    idap_pkg::status_e status;
    logic [7:0]        id;
    logic [31:0]       payload;
    logic [8:0]        used;
    logic [8:0]        free;
  } pool_reply_t;

  // Mirror of the pool
  bit          id_taken   [NUM_IDS];
  logic [31:0] id_payload [NUM_IDS];
  int          ids_in_use;
  int          alloc_hint;

  pool_reply_t replies_q [$];

  // Applies one request beat to the mirror and returns the reply it should give
  function automatic pool_reply_t compute_pool_reply(input logic [1:0]  op,
                                                     input logic [7:0]  tid,
                                                     input logic [31:0] pin);
    pool_reply_t r;
    int          slot;
    int          i;
    r.status  = idap_pkg::STATUS_OK;
    r.id      = tid;
    r.payload = '0;
    slot      = -1;
    case (op)
      idap_pkg::KIND_INSERT: begin
        // lowest free id at or above the hint; nothing below it is considered
        for (i = alloc_hint; i < NUM_IDS && slot < 0; i++)
          if (!id_taken[i]) slot = i;
        if (slot < 0) begin
          r.status = idap_pkg::STATUS_FULL;
          r.id     = '0;
        end else begin
          id_taken[slot]   = 1'b1;
          id_payload[slot] = pin;
          ids_in_use++;
          alloc_hint = slot + 1;
          r.id       = slot[7:0];
        end
      end
      idap_pkg::KIND_REMOVE, idap_pkg::KIND_FIND: begin
        if (int'(tid) < NUM_IDS && id_taken[tid]) begin
          r.payload = id_payload[tid];
          if (op == idap_pkg::KIND_REMOVE) begin
            id_taken[tid] = 1'b0;
            if (ids_in_use > 0) ids_in_use--;
            if (int'(tid) < alloc_hint) alloc_hint = int'(tid);
          end
        end else begin
          r.status = idap_pkg::STATUS_NOT_USED;
        end
      end
      default: ;  // unknown kind: echo the id, touch nothing
    endcase
    r.used = ids_in_use[8:0];
    r.free = 9'(NUM_IDS - ids_in_use);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pool_reply_t want;
    pool_reply_t got;
    if (!rst_ni) begin
      foreach (id_taken[k]) id_taken[k] = 1'b0;
      ids_in_use    = 0;
      alloc_hint    = 0;
      replies_q.delete();
      outstanding_o = 0;
    end else begin
      // result first: it can only belong to a beat taken at an earlier edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = idap_pkg::status_e'(m_axis_tuser);
        got.id      = m_axis_tdata[7:0];
        got.payload = m_axis_tdata[39:8];
        got.used    = m_axis_tdata[48:40];
        got.free    = m_axis_tdata[57:49];
        if (replies_q.size() == 0) begin
          $display("%0t: result beat with no request open, expected none, actual %0h",
                   $time, m_axis_tdata);
          fail_count_o++;
        end else begin
          want = replies_q.pop_front();
          if (got.status !== want.status)
            note_mismatch("status", 32'(want.status), 32'(got.status));
          if (got.id !== want.id)
            note_mismatch("result_id", 32'(want.id), 32'(got.id));
          if (got.payload !== want.payload)
            note_mismatch("payload_out", want.payload, got.payload);
          if (got.used !== want.used)
            note_mismatch("used_count", 32'(want.used), 32'(got.used));
          if (got.free !== want.free)
            note_mismatch("free_count", 32'(want.free), 32'(got.free));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        replies_q.push_back(compute_pool_reply(s_axis_tuser, s_axis_tdata[7:0],
                                               s_axis_tdata[39:8]));
      outstanding_o = replies_q.size();
    end
  end

endmodule

[verif/testbench.sv]
// Testbench top: drives request beats and result back-pressure into the id allocator
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_UNKNOWN    = 2'd3;
  localparam int         NUM_IDS         = 256;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         HOLD_OFF_CYCLES = 300;
  localparam int         DRAIN_CYCLES    = 24;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // target_id[7:0], payload_in[39:8]
  logic [1:0]  s_axis_tuser  = '0;   // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // result_id, payload_out, used_count, free_count
  logic [1:0]  m_axis_tuser;         // status[1:0]

  int fail_count;
  int outstanding;
  bit tx_gaps_on   = 1'b1;
  bit rx_gaps_on   = 1'b1;
  bit hold_off_req = 1'b0;
  int id_limits [3] = '{15, 63, 255};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  id_allocator_with_payload_core #(
    .NUM_IDS       (NUM_IDS),
    .PAYLOAD_WIDTH (32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  id_pool_checker #(
    .NUM_IDS (NUM_IDS)
  ) pool_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // One request beat; returns at the edge that takes it, then maybe idles
  task automatic offer(input logic [1:0] op, input logic [7:0] tid,
                       input logic [31:0] pin);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pin, tid};
    do @(posedge clk_i); while (!s_axis_tready);
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Random mix; target ids mostly at or below id_hi, where allocated ids cluster
  task automatic random_ops(input int count, input int insert_pct,
                            input int remove_pct, input int id_hi);
    int         roll;
    logic [1:0] op;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < insert_pct)                   op = idap_pkg::KIND_INSERT;
      else if (roll < insert_pct + remove_pct) op = idap_pkg::KIND_REMOVE;
      else if (roll < 98)                      op = idap_pkg::KIND_FIND;
      else                                     op = KIND_UNKNOWN;
      offer(op, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, id_hi)),
            $urandom);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    bit hold_off_done;
    hold_off_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int base;
    int c;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pool: nothing to find or remove
    offer(idap_pkg::KIND_FIND,   8'h00, 32'h0000_0000);
    offer(idap_pkg::KIND_REMOVE, 8'hFF, 32'hFFFF_FFFF);
    // first allocations, target id ignored, payload extremes
    offer(idap_pkg::KIND_INSERT, 8'hFF, 32'h0000_0000);
    offer(idap_pkg::KIND_INSERT, 8'h00, 32'hFFFF_FFFF);
    offer(idap_pkg::KIND_INSERT, 8'h55, 32'h8000_0001);
    offer(idap_pkg::KIND_FIND,   8'h01, 32'h0000_0000);
    offer(idap_pkg::KIND_FIND,   8'h00, 32'hFFFF_FFFF);
    offer(idap_pkg::KIND_FIND,   8'h02, 32'h1234_5678);
    // free an id below the hint, then reuse it
    offer(idap_pkg::KIND_REMOVE, 8'h01, 32'h0000_0000);
    offer(idap_pkg::KIND_REMOVE, 8'h01, 32'h0000_0000);
    offer(idap_pkg::KIND_FIND,   8'h01, 32'h0000_0000);
    offer(idap_pkg::KIND_INSERT, 8'hAA, 32'h5A5A_A5A5);
    offer(idap_pkg::KIND_INSERT, 8'h00, 32'hA5A5_5A5A);
    offer(idap_pkg::KIND_REMOVE, 8'h00, 32'h0000_0000);
    offer(idap_pkg::KIND_INSERT, 8'h80, 32'h7FFF_FFFE);
    // unknown kind echoes the id and changes nothing
    offer(KIND_UNKNOWN,          8'hFF, 32'hFFFF_FFFF);
    offer(KIND_UNKNOWN,          8'h00, 32'h0000_0000);
    offer(idap_pkg::KIND_FIND,   8'hFF, 32'h0000_0000);
    offer(idap_pkg::KIND_REMOVE, 8'hAA, 32'h0000_0000);

    // mostly inserts: hint runs to the top, pool-full replies follow
    random_ops(330, 85, 5, 255);

    // back-to-back requests while the result side holds off
    tx_gaps_on   = 1'b0;
    hold_off_req = 1'b1;
    random_ops(60, 40, 40, 255);
    tx_gaps_on   = 1'b1;

    for (c = 0; c < 10; c++)
      random_ops(50, 40, 35, id_limits[$urandom_range(0, 2)]);

    // free every id once, starting at a random point
    base = $urandom_range(0, NUM_IDS - 1);
    for (c = 0; c < NUM_IDS; c++)
      offer(idap_pkg::KIND_REMOVE, 8'(base + c), $urandom);

    // last stretch at full rate on both sides
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    random_ops(330, 55, 30, 63);

    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
